/* rtl/fdz_pkg.sv */
// ----------------------------------------------------------------------------
// fdz_pkg
// Shared types, constants and default parameters of the z-scan search unit.
// ----------------------------------------------------------------------------
package fdz_pkg;

	// default geometry
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;
	localparam int DEF_UNIT_SIZE  = 64;
	localparam int DEF_LEAF_SIZE  = 4;

	// flag store word: blocks per memory row
	localparam int WORD_BITS = 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_DIFF    = 2'd2;

	localparam logic [11:0] RST_FRAME_WIDTH  = 12'd2048;
	localparam logic [11:0] RST_FRAME_HEIGHT = 12'd2048;

	localparam logic [7:0] GRAY_LEVEL = 8'd130;

	localparam int UIDX_W = 10;

	typedef struct packed {
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
		logic [7:0]  pixel_red;
		logic [7:0]  pixel_green;
		logic [7:0]  pixel_blue;
		logic        frame_last;
	} pixel_t;

	typedef struct packed {
		logic              found;
		logic [UIDX_W-1:0] unit_index;
		logic [10:0]       first_x;
		logic [10:0]       first_y;
		logic [7:0]        part_index;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic mark;   // pixel word accepted this cycle
		logic start;  // last pixel accepted: arm the scan
		logic scan;   // scan in progress
		logic load;   // copy scan result to output register
		logic clear;  // clearing sweep step
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;        // marked block found this cycle
		logic exhausted;  // walk finished without a hit
		logic clr_last;   // final row of clearing sweep
	} sts_t;

endpackage

/* rtl/fdz_ctrl.sv */
// ----------------------------------------------------------------------------
// fdz_ctrl
// Sequencer: clearing sweep, pixel intake, scan and result hand-off.
// ----------------------------------------------------------------------------
module fdz_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	input  logic        pixel_last,
	output logic        pixel_ready,
	output logic        result_valid,
	input  logic        result_ready,
	output fdz_pkg::cmd_t cmd,
	input  fdz_pkg::sts_t sts
);
	import fdz_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   out_free;
	logic   accept;

	assign pixel_ready = (state_q == ST_IDLE);
	assign accept      = pixel_valid && pixel_ready;
	assign out_free    = !result_valid || result_ready;

	always_comb begin
		cmd       = '0;
		cmd.mark  = accept;
		cmd.start = accept && pixel_last;
		cmd.scan  = (state_q == ST_SCAN);
		cmd.load  = (state_q == ST_HOLD) && out_free;
		cmd.clear = (state_q == ST_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			result_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.hit || sts.exhausted) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_CLEAR;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

/* rtl/fdz_dpath.sv */
// ----------------------------------------------------------------------------
// fdz_dpath
// Configuration, block flag store, z-order walk and result registers.
// ----------------------------------------------------------------------------
module fdz_dpath #(
	parameter int MAX_WIDTH  = fdz_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = fdz_pkg::DEF_MAX_HEIGHT,
	parameter int UNIT_SIZE  = fdz_pkg::DEF_UNIT_SIZE,
	parameter int LEAF_SIZE  = fdz_pkg::DEF_LEAF_SIZE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [fdz_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fdz_pkg::CFG_DATA_W-1:0] cfg_data,
	input  fdz_pkg::pixel_t                pixel,
	output fdz_pkg::result_t               result,
	input  fdz_pkg::cmd_t                  cmd,
	output fdz_pkg::sts_t                  sts
);
	import fdz_pkg::*;

	localparam int LB        = $clog2(LEAF_SIZE);
	localparam int BLK_COLS  = MAX_WIDTH / LEAF_SIZE;
	localparam int BLK_ROWS  = MAX_HEIGHT / LEAF_SIZE;
	localparam int UNIT_BLKS = UNIT_SIZE / LEAF_SIZE;
	localparam int ZN        = UNIT_BLKS * UNIT_BLKS;
	localparam int ZW        = $clog2(ZN);
	localparam int CW        = (ZW + 1) / 2;
	localparam int WB        = $clog2(WORD_BITS);
	localparam int WA_LOG    = $clog2((BLK_COLS + WORD_BITS - 1) / WORD_BITS);
	localparam int ROW_LOG   = $clog2(BLK_ROWS);
	localparam int AW        = ROW_LOG + WA_LOG;
	localparam int DEPTH     = BLK_ROWS * (2 ** WA_LOG);
	localparam int XW        = $clog2(MAX_WIDTH + UNIT_SIZE);
	localparam int YW        = $clog2(MAX_HEIGHT + UNIT_SIZE);

	// configuration
	logic [11:0] frame_width_q;
	logic [11:0] frame_height_q;
	logic        mark_diff_q;
	logic [XW-1:0] eff_w;
	logic [YW-1:0] eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			mark_diff_q    <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[11:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[11:0];
				REG_MARK_DIFF:    mark_diff_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// saturate to the store size
	assign eff_w = (32'(frame_width_q) > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(frame_width_q);
	assign eff_h = (32'(frame_height_q) > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
		: YW'(frame_height_q);

	// pixel marking
	logic [10:0]         mk_bx, mk_by;
	logic                mk_diff, mk_en;
	logic [AW-1:0]       mk_addr;
	logic [WB-1:0]       mk_bit;

	always_comb begin
		mk_bx = pixel.pixel_x >> LB;
		mk_by = pixel.pixel_y >> LB;
		if (mark_diff_q) begin
			mk_diff = (pixel.pixel_red != 8'd0) || (pixel.pixel_green != 8'd0)
				|| (pixel.pixel_blue != 8'd0);
		end else begin
			mk_diff = (pixel.pixel_red != GRAY_LEVEL) || (pixel.pixel_green != GRAY_LEVEL)
				|| (pixel.pixel_blue != GRAY_LEVEL);
		end
		mk_en = cmd.mark && mk_diff
			&& (32'(pixel.pixel_x) < 32'(eff_w)) && (32'(pixel.pixel_y) < 32'(eff_h))
			&& (32'(mk_bx) < 32'(BLK_COLS)) && (32'(mk_by) < 32'(BLK_ROWS));
		mk_addr = {ROW_LOG'(mk_by), WA_LOG'(mk_bx >> WB)};
		mk_bit  = WB'(mk_bx);
	end

	// walk: issue stage
	logic [ZW-1:0]     zc_q;
	logic [XW-1:0]     uox_q;
	logic [YW-1:0]     uoy_q;
	logic [UIDX_W-1:0] uidx_q;
	logic              issue_done_q;
	logic              issue;
	logic [CW-1:0]     cx, cy;
	logic [XW-1:0]     x0, bx0;
	logic [YW-1:0]     y0, by0;
	logic [AW-1:0]     sc_addr;

	assign issue = cmd.scan && !issue_done_q;

	always_comb begin
		cx = '0;
		cy = '0;
		for (int k = 0; k < CW; k++) begin
			cx[k] = zc_q[2*k];
			if (2*k + 1 < ZW) begin
				cy[k] = zc_q[2*k+1];
			end
		end
		x0  = uox_q + (XW'(cx) << LB);
		y0  = uoy_q + (YW'(cy) << LB);
		bx0 = x0 >> LB;
		by0 = y0 >> LB;
		sc_addr = {ROW_LOG'(by0), WA_LOG'(bx0 >> WB)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zc_q         <= '0;
			uox_q        <= '0;
			uoy_q        <= '0;
			uidx_q       <= '0;
			issue_done_q <= 1'b1;
		end else if (cmd.start) begin
			zc_q         <= '0;
			uox_q        <= '0;
			uoy_q        <= '0;
			uidx_q       <= '0;
			issue_done_q <= (eff_w == '0) || (eff_h == '0);
		end else if (issue) begin
			if (zc_q == ZW'(ZN - 1)) begin
				zc_q   <= '0;
				uidx_q <= uidx_q + 1'b1;
				if (32'(uox_q) + 32'(UNIT_SIZE) < 32'(eff_w)) begin
					uox_q <= uox_q + XW'(UNIT_SIZE);
				end else begin
					uox_q <= '0;
					if (32'(uoy_q) + 32'(UNIT_SIZE) < 32'(eff_h)) begin
						uoy_q <= uoy_q + YW'(UNIT_SIZE);
					end else begin
						issue_done_q <= 1'b1;
					end
				end
			end else begin
				zc_q <= zc_q + 1'b1;
			end
		end
	end

	// flag store: bit-masked set, word clear, registered read
	logic [WORD_BITS-1:0] flag_mem [DEPTH];
	logic [WORD_BITS-1:0] rd_q;
	logic [AW-1:0]        clr_q;

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			flag_mem[clr_q] <= '0;
		end else if (mk_en) begin
			flag_mem[mk_addr][mk_bit] <= 1'b1;
		end
		rd_q <= flag_mem[sc_addr];
	end

	assign sts.clr_last = (clr_q == AW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= sts.clr_last ? '0 : clr_q + 1'b1;
		end
	end

	// walk: evaluate stage
	logic              vld_s1;
	logic              inpic_s1, inrange_s1, first_s1;
	logic [WB-1:0]     bit_s1;
	logic [XW-1:0]     x0_s1;
	logic [YW-1:0]     y0_s1;
	logic [UIDX_W-1:0] uidx_s1;
	logic [ZW-1:0]     cnt_q, cnt_base;
	logic              hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		inpic_s1   <= (32'(x0) < 32'(eff_w)) && (32'(y0) < 32'(eff_h));
		inrange_s1 <= (32'(bx0) < 32'(BLK_COLS)) && (32'(by0) < 32'(BLK_ROWS));
		first_s1   <= (zc_q == '0);
		bit_s1     <= WB'(bx0);
		x0_s1      <= x0;
		y0_s1      <= y0;
		uidx_s1    <= uidx_q;
	end

	assign cnt_base      = first_s1 ? '0 : cnt_q;
	assign hit           = cmd.scan && vld_s1 && inpic_s1 && inrange_s1 && rd_q[bit_s1];
	assign sts.hit       = hit;
	assign sts.exhausted = cmd.scan && issue_done_q && !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.scan && vld_s1 && !hit) begin
			cnt_q <= cnt_base + ZW'(inpic_s1);
		end
	end

	// result registers
	result_t scan_res_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			scan_res_q <= '0;
		end else if (hit) begin
			scan_res_q.found      <= 1'b1;
			scan_res_q.unit_index <= uidx_s1;
			scan_res_q.first_x    <= 11'(x0_s1);
			scan_res_q.first_y    <= 11'(y0_s1);
			scan_res_q.part_index <= 8'(cnt_base);
		end
		if (cmd.load) begin
			result <= scan_res_q;
		end
	end

endmodule

/* rtl/first_difference_zscan_search_unit.sv */
// ----------------------------------------------------------------------------
// first_difference_zscan_search_unit
// Finds the first differing 4x4 block of a difference image in z-scan order.
// ----------------------------------------------------------------------------
// Usage:
//  - pixel channel (valid/ready): one difference pixel per word with its x/y.
//    Differing pixels inside the configured picture mark their block in a flag store.
//    One word per cycle while pixel_ready is high.
//  - frame_last on a word starts the search once that pixel is marked.
//    The walk visits units in raster order and the blocks of each unit in
//    z-order, one block a cycle, and stops at the first marked block.
//  - result channel (valid/ready): exactly one word per frame, found = 0
//    with zero fields when nothing was marked.
//  - after each result is loaded, and after reset, the store is swept clear
//    one row a cycle; pixel_ready stays low meanwhile.
//  - a stalled receiver holds the result in the output register; the next
//    frame is taken in and only its result waits for the register to drain.
//  - configuration writes are to be made while no frame is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module first_difference_zscan_search_unit #(
	parameter int MAX_WIDTH  = fdz_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = fdz_pkg::DEF_MAX_HEIGHT,
	parameter int UNIT_SIZE  = fdz_pkg::DEF_UNIT_SIZE,
	parameter int LEAF_SIZE  = fdz_pkg::DEF_LEAF_SIZE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_write_en,
	input  logic [fdz_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fdz_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel words
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  fdz_pkg::pixel_t                pixel,
	// result words
	output logic                           result_valid,
	input  logic                           result_ready,
	output fdz_pkg::result_t               result
);
	import fdz_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	fdz_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_last   (pixel.frame_last),
		.pixel_ready  (pixel_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	// flag store, walk and result registers
	fdz_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.UNIT_SIZE  (UNIT_SIZE),
		.LEAF_SIZE  (LEAF_SIZE)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel        (pixel),
		.result       (result),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
